@@ rtl/core/hsp_pkg.sv @@
// Shared types, codes and character helpers for the hex string parser.
// No dependencies; every other file of the block refers to this package.
package hsp_pkg;

    // Default sizing
    localparam int MAX_BYTES_DEF   = 8;
    localparam int OFFSET_BITS_DEF = 16;

    // Payload widths
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef logic [STATUS_W-1:0] status_t;

    // Result status codes
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_INVALID  = 2'd1;
    localparam status_t ST_OVERFLOW = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_STRICT = 1'b0;
    localparam logic REG_VBYTES = 1'b1;

    localparam logic [3:0] VBYTES_RESET = 4'd8;

    // Characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] UP_BIAS  = 8'h37;
    localparam logic [CHAR_W-1:0] LOW_BIAS = 8'h57;

    // True for 0-9, A-F, a-f
    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Nibble of a hex character; only meaningful when is_hex holds
    function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        if (c <= 8'h39)
            d = c - CH_ZERO;
        else if (c <= 8'h46)
            d = c - UP_BIAS;
        else
            d = c - LOW_BIAS;
        return d[3:0];
    endfunction

    // CR, LF or ASCII punctuation
    function automatic logic is_terminator(input logic [CHAR_W-1:0] c);
        return (c == CH_LF) || (c == CH_CR) ||
               (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

endpackage

@@ rtl/core/hsp_char_if.sv @@
// Character channel: one ASCII character per beat, valid/ready handshake.
// Depends on hsp_pkg for the character width.
interface hsp_char_if;
    logic                       valid;
    logic                       ready;
    logic [hsp_pkg::CHAR_W-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

@@ rtl/core/hsp_result_if.sv @@
// Result channel: parsed value, status and stop offset, valid/ready handshake.
// Depends on hsp_pkg for widths and the status type.
interface hsp_result_if;
    logic                         valid;
    logic                         ready;
    logic [hsp_pkg::VALUE_W-1:0]  value;
    hsp_pkg::status_t             status;
    logic [hsp_pkg::OFFSET_W-1:0] stop_offset;

    modport source (output valid, output value, output status, output stop_offset,
                    input ready);
    modport sink   (input valid, input value, input status, input stop_offset,
                    output ready);
endinterface

@@ rtl/core/hex_string_parser.sv @@
// Channel      | Dir | Payload                              | Beat
// char_in      | in  | character[7:0]                       | one character
// result_out   | out | value[63:0] status[1:0] stop_offset  | one parsed number
// apb          | in  | paddr[2:0] pwdata/prdata[31:0]       | strict_mode @0, value_bytes @4
//
// One character is taken per cycle unless char_in stalls; the parse state updates in the same cycle.
// A result is registered on its NUL beat and held until taken.
// char_in stalls only while a result waits in the output register unread.
// rst_n (async, active low) returns to skipping leading spaces, defaults regs.
// Depends on hsp_pkg, hsp_char_if and hsp_result_if.
module hex_string_parser #(
    parameter int MAX_BYTES   = hsp_pkg::MAX_BYTES_DEF,
    parameter int OFFSET_BITS = hsp_pkg::OFFSET_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hsp_pkg::APB_AW-1:0] paddr,
    input  logic [hsp_pkg::APB_DW-1:0] pwdata,
    output logic [hsp_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    hsp_char_if.sink                   char_in,
    hsp_result_if.source               result_out
);

    localparam int ACC_W = 8 * MAX_BYTES;
    localparam int CNT_W = $clog2(2 * MAX_BYTES + 1);
    localparam logic [3:0] MAX_B4 = 4'(MAX_BYTES);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_ZERO1,
        PH_ZEROS,
        PH_DIGITS,
        PH_TRAIL,
        PH_DONE
    } phase_t;

    // Configuration registers
    logic       strict_reg;
    logic [3:0] vbytes_reg;

    // Parse state
    phase_t                  phase_reg, phase_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    saw_zero_reg, saw_zero_next;
    logic [OFFSET_BITS-1:0]  index_reg, index_next;
    logic [OFFSET_BITS-1:0]  stop_reg, stop_next;
    hsp_pkg::status_t        pend_reg, pend_next;

    // Output register
    logic                         out_valid_reg;
    logic [hsp_pkg::VALUE_W-1:0]  out_value_reg;
    hsp_pkg::status_t             out_status_reg;
    logic [hsp_pkg::OFFSET_W-1:0] out_stop_reg;

    logic                         accept;
    logic                         emit;
    hsp_pkg::status_t             emit_status;
    logic                         run_digit;
    logic                         empty;
    logic [3:0]                   vb_clamped;
    logic [4:0]                   limit;
    logic [hsp_pkg::CHAR_W-1:0]   c;

    // APB register file
    assign pready = 1'b1;

    always_comb
    begin
        if (paddr[2] == hsp_pkg::REG_STRICT)
            prdata = {{(hsp_pkg::APB_DW-1){1'b0}}, strict_reg};
        else
            prdata = {{(hsp_pkg::APB_DW-4){1'b0}}, vbytes_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg <= 1'b0;
            vbytes_reg <= hsp_pkg::VBYTES_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == hsp_pkg::REG_STRICT)
                strict_reg <= pwdata[0];
            else
                vbytes_reg <= pwdata[3:0];
        end
    end

    // Take a character whenever the result register is free or draining
    assign char_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = char_in.valid && char_in.ready;
    assign c             = char_in.character;

    assign vb_clamped = (vbytes_reg > MAX_B4) ? MAX_B4 : vbytes_reg;
    assign limit      = {vb_clamped, 1'b0};

    // Next parse state for the character on the input
    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        count_next    = count_reg;
        saw_zero_next = saw_zero_reg;
        stop_next     = stop_reg;
        pend_next     = pend_reg;
        emit          = 1'b0;
        emit_status   = hsp_pkg::ST_OK;
        run_digit     = 1'b0;

        unique case (phase_reg)
            PH_LEAD:
            begin
                if (c == hsp_pkg::CH_ZERO)
                    phase_next = PH_ZERO1;
                else if (c != hsp_pkg::CH_SPACE)
                    run_digit = 1'b1;
            end
            PH_ZERO1:
            begin
                phase_next = PH_ZEROS;
                if (c != hsp_pkg::CH_LOW_X && c != hsp_pkg::CH_UP_X)
                begin
                    saw_zero_next = 1'b1;
                    run_digit     = (c != hsp_pkg::CH_ZERO);
                end
            end
            PH_ZEROS:
            begin
                if (c == hsp_pkg::CH_ZERO)
                    saw_zero_next = 1'b1;
                else
                    run_digit = 1'b1;
            end
            PH_DIGITS:
                run_digit = 1'b1;
            PH_TRAIL:
            begin
                if (c == hsp_pkg::CH_NUL)
                begin
                    stop_next   = index_reg;
                    emit        = 1'b1;
                    emit_status = hsp_pkg::ST_OK;
                end
                else if (c != hsp_pkg::CH_SPACE)
                begin
                    pend_next  = hsp_pkg::ST_INVALID;
                    stop_next  = index_reg;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                if (c == hsp_pkg::CH_NUL)
                begin
                    emit        = 1'b1;
                    emit_status = pend_reg;
                end
            end
            default:
                phase_next = PH_LEAD;
        endcase

        empty = (count_reg == '0) && !saw_zero_next;

        // Number body: digits and the character that ends them
        if (run_digit)
        begin
            phase_next = PH_DIGITS;
            if (c == hsp_pkg::CH_NUL)
            begin
                stop_next   = index_reg;
                emit        = 1'b1;
                emit_status = empty ? hsp_pkg::ST_INVALID : hsp_pkg::ST_OK;
            end
            else if (c == hsp_pkg::CH_SPACE)
            begin
                if (!empty && strict_reg)
                begin
                    pend_next  = hsp_pkg::ST_OK;
                    phase_next = PH_TRAIL;
                end
                else
                begin
                    pend_next  = empty ? hsp_pkg::ST_INVALID : hsp_pkg::ST_OK;
                    stop_next  = index_reg;
                    phase_next = PH_DONE;
                end
            end
            else if (hsp_pkg::is_hex(c))
            begin
                if (5'(count_reg) >= limit)
                begin
                    pend_next  = hsp_pkg::ST_OVERFLOW;
                    stop_next  = index_reg;
                    phase_next = PH_DONE;
                end
                else
                begin
                    acc_next   = {acc_reg[ACC_W-5:0], hsp_pkg::hex_nibble(c)};
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (!strict_reg && hsp_pkg::is_terminator(c) && !empty)
                    pend_next = hsp_pkg::ST_OK;
                else
                    pend_next = hsp_pkg::ST_INVALID;
                stop_next  = index_reg;
                phase_next = PH_DONE;
            end
        end

        // Advance the saturating character index
        if (index_reg != '1)
            index_next = index_reg + 1'b1;
        else
            index_next = index_reg;
    end

    // Hold parse state; clear it after each result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            acc_reg      <= '0;
            count_reg    <= '0;
            saw_zero_reg <= 1'b0;
            index_reg    <= '0;
            stop_reg     <= '0;
            pend_reg     <= hsp_pkg::ST_OK;
        end
        else if (accept)
        begin
            if (emit)
            begin
                phase_reg    <= PH_LEAD;
                acc_reg      <= '0;
                count_reg    <= '0;
                saw_zero_reg <= 1'b0;
                index_reg    <= '0;
                stop_reg     <= '0;
                pend_reg     <= hsp_pkg::ST_OK;
            end
            else
            begin
                phase_reg    <= phase_next;
                acc_reg      <= acc_next;
                count_reg    <= count_next;
                saw_zero_reg <= saw_zero_next;
                index_reg    <= index_next;
                stop_reg     <= stop_next;
                pend_reg     <= pend_next;
            end
        end
    end

    // Result register: load on a NUL beat, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && emit)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_value_reg  <= (emit_status == hsp_pkg::ST_OK) ?
                              hsp_pkg::VALUE_W'(acc_reg) : '0;
            out_status_reg <= emit_status;
            out_stop_reg   <= hsp_pkg::OFFSET_W'(stop_next);
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.value       = out_value_reg;
    assign result_out.status      = out_status_reg;
    assign result_out.stop_offset = out_stop_reg;

endmodule

@@ rtl/core/hsp_checker.sv @@
// Port-level checks for hex_string_parser, attached with a bind below.
// Depends on hsp_pkg for widths and status codes.
module hsp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [hsp_pkg::VALUE_W-1:0]  out_value,
    input hsp_pkg::status_t             out_status
);

    // A waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A new result only follows an accepted character
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without a character beat");

    // Status is one of the three defined codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == hsp_pkg::ST_OK ||
                       out_status == hsp_pkg::ST_INVALID ||
                       out_status == hsp_pkg::ST_OVERFLOW))
        else $error("undefined status code");

    // A failed parse reports a zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != hsp_pkg::ST_OK |-> out_value == '0)
        else $error("nonzero value on failed parse");

    // Input is never stalled while the result register is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("character stalled with empty result register");

endmodule

bind hex_string_parser hsp_checker u_hsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (char_in.valid),
    .in_ready  (char_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_value (result_out.value),
    .out_status(result_out.status)
);

@@ tb/testbench.sv @@
// Self-checking bench for hex_string_parser: drives character beats, predicts each
// parse result and compares it with the result channel. Needs hsp_pkg, hsp_char_if,
// hsp_result_if and the hex_string_parser RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_ZERO1,
        SCAN_ZEROS,
        SCAN_DIGITS,
        SCAN_TRAIL,
        SCAN_DONE
    } scan_phase_t;

    typedef struct packed {
        logic [hsp_pkg::VALUE_W-1:0]  value;
        hsp_pkg::status_t             status;
        logic [hsp_pkg::OFFSET_W-1:0] offset;
    } parse_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [hsp_pkg::APB_AW-1:0] paddr;
    logic [hsp_pkg::APB_DW-1:0] pwdata;
    logic [hsp_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    hsp_char_if   char_bus ();
    hsp_result_if result_bus ();

    hex_string_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .char_in    (char_bus),
        .result_out (result_bus)
    );

    // Register shadow, as last written over APB
    logic       cfg_strict = 1'b0;
    logic [3:0] cfg_vbytes = hsp_pkg::VBYTES_RESET;

    // Parser shadow state
    scan_phase_t                  scan        = SCAN_LEAD;
    logic [hsp_pkg::VALUE_W-1:0]  acc         = '0;
    int                           digit_cnt   = 0;
    bit                           saw_zero    = 1'b0;
    logic [hsp_pkg::OFFSET_W-1:0] char_idx    = '0;
    logic [hsp_pkg::OFFSET_W-1:0] stop_idx    = '0;
    hsp_pkg::status_t             pend_status = hsp_pkg::ST_OK;

    logic [hsp_pkg::CHAR_W-1:0] text_bytes[$];
    parse_result_t              expected_parses[$];
    int                         chars_queued   = 0;
    int                         chars_taken    = 0;
    int                         mismatches     = 0;
    int                         idle_cycles    = 0;
    int                         send_gap_pct   = 0;
    int                         take_stall_pct = 0;
    bit                         squeeze_start  = 1'b0;
    logic                       hold_results   = 1'b0;

    string hex_pool   = "0123456789abcdefABCDEF";
    string punct_pool = "!\"#$%&'()*+,-./:;<=>?@[\\]^_`{|}~";

    // ---------------------------------------------------------------- predictor

    function automatic int nibble_of(input logic [hsp_pkg::CHAR_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 'h37;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 'h57;
        return -1;
    endfunction

    // CR, LF and ASCII punctuation close a number outside strict mode
    function automatic bit ends_number(input logic [hsp_pkg::CHAR_W-1:0] c);
        return (c == hsp_pkg::CH_LF) || (c == hsp_pkg::CH_CR) ||
               (c >= 8'h21 && c <= 8'h2F) ||
               (c >= 8'h3A && c <= 8'h40) || (c >= 8'h5B && c <= 8'h60) ||
               (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function automatic void settle(input hsp_pkg::status_t st);
        pend_status = st;
        stop_idx    = char_idx;
        scan        = SCAN_DONE;
    endfunction

    // Queue the result for this string and start over on the next one
    function automatic void close_string(input hsp_pkg::status_t st);
        parse_result_t r;
        r.value  = (st == hsp_pkg::ST_OK) ? acc : '0;
        r.status = st;
        r.offset = stop_idx;
        expected_parses.push_back(r);
        scan        = SCAN_LEAD;
        acc         = '0;
        digit_cnt   = 0;
        saw_zero    = 1'b0;
        char_idx    = '0;
        stop_idx    = '0;
        pend_status = hsp_pkg::ST_OK;
    endfunction

    // One character of the number body; returns 1 when a result is produced
    function automatic bit number_char(input logic [hsp_pkg::CHAR_W-1:0] c);
        bit empty;
        int limit;
        int nib;
        empty = (digit_cnt == 0) && !saw_zero;
        limit = ((cfg_vbytes > hsp_pkg::MAX_BYTES_DEF) ? hsp_pkg::MAX_BYTES_DEF
                                                       : int'(cfg_vbytes)) * 2;
        nib   = nibble_of(c);
        scan  = SCAN_DIGITS;
        if (c == hsp_pkg::CH_NUL)
        begin
            stop_idx = char_idx;
            close_string(empty ? hsp_pkg::ST_INVALID : hsp_pkg::ST_OK);
            return 1'b1;
        end
        if (c == hsp_pkg::CH_SPACE)
        begin
            if (empty)
                settle(hsp_pkg::ST_INVALID);
            else if (cfg_strict)
            begin
                pend_status = hsp_pkg::ST_OK;
                scan        = SCAN_TRAIL;
            end
            else
                settle(hsp_pkg::ST_OK);
        end
        else if (nib >= 0)
        begin
            if (digit_cnt >= limit)
                settle(hsp_pkg::ST_OVERFLOW);
            else
            begin
                acc = {acc[hsp_pkg::VALUE_W-5:0], 4'(nib)};
                digit_cnt++;
            end
        end
        else if (!cfg_strict && ends_number(c) && !empty)
            settle(hsp_pkg::ST_OK);
        else
            settle(hsp_pkg::ST_INVALID);
        return 1'b0;
    endfunction

    function automatic void parse_char(input logic [hsp_pkg::CHAR_W-1:0] c);
        bit done;
        done = 1'b0;
        case (scan)
            SCAN_LEAD:
            begin
                if (c == hsp_pkg::CH_ZERO)
                    scan = SCAN_ZERO1;
                else if (c != hsp_pkg::CH_SPACE)
                    done = number_char(c);
            end
            SCAN_ZERO1:
            begin
                scan = SCAN_ZEROS;
                if (c != hsp_pkg::CH_LOW_X && c != hsp_pkg::CH_UP_X)
                begin
                    saw_zero = 1'b1;
                    if (c != hsp_pkg::CH_ZERO)
                        done = number_char(c);
                end
            end
            SCAN_ZEROS:
            begin
                if (c == hsp_pkg::CH_ZERO)
                    saw_zero = 1'b1;
                else
                    done = number_char(c);
            end
            SCAN_DIGITS:
                done = number_char(c);
            SCAN_TRAIL:
            begin
                if (c == hsp_pkg::CH_NUL)
                begin
                    stop_idx = char_idx;
                    close_string(hsp_pkg::ST_OK);
                    done = 1'b1;
                end
                else if (c != hsp_pkg::CH_SPACE)
                    settle(hsp_pkg::ST_INVALID);
            end
            default:
            begin
                if (c == hsp_pkg::CH_NUL)
                begin
                    close_string(pend_status);
                    done = 1'b1;
                end
            end
        endcase
        if (!done && char_idx != '1)
            char_idx++;
    endfunction

    // ---------------------------------------------------------------- clock

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- character driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_bus.valid     <= 1'b0;
            char_bus.character <= '0;
        end
        else
        begin
            // predict on every accepted beat
            if (char_bus.valid && char_bus.ready)
            begin
                parse_char(char_bus.character);
                chars_taken++;
            end
            // advance to the next character, or drop valid for a gap
            if (!char_bus.valid || char_bus.ready)
            begin
                if (text_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    char_bus.valid     <= 1'b1;
                    char_bus.character <= text_bytes.pop_front();
                end
                else
                    char_bus.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- result monitor

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_parses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %h status %0d offset %0d",
                                 result_bus.value, result_bus.status,
                                 result_bus.stop_offset);
                end
                else
                begin
                    parse_result_t want;
                    want = expected_parses.pop_front();
                    if (result_bus.value !== want.value || result_bus.status !== want.status ||
                        result_bus.stop_offset !== want.offset)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected value %h status %0d offset %0d,",
                                      " got value %h status %0d offset %0d"},
                                     want.value, want.status, want.offset,
                                     result_bus.value, result_bus.status,
                                     result_bus.stop_offset);
                    end
                end
            end
            result_bus.ready <= !hold_results && ($urandom_range(99) >= take_stall_pct);
        end
    end

    // Hold off the result side long enough for the input to back up
    initial
    begin
        wait (squeeze_start);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        if (!rst_n || (char_bus.valid && char_bus.ready) ||
            (result_bus.valid && result_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------- stimulus helpers

    task automatic push_char(input logic [hsp_pkg::CHAR_W-1:0] c);
        text_bytes.push_back(c);
        chars_queued++;
    endtask

    task automatic push_text(input string s, input bit with_nul = 1'b1);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
        if (with_nul)
            push_char(hsp_pkg::CH_NUL);
    endtask

    task automatic write_reg(input logic idx, input logic [hsp_pkg::APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == hsp_pkg::REG_STRICT)
            cfg_strict = data[0];
        else
            cfg_vbytes = data[3:0];
    endtask

    // Wait for every queued beat and every result, then let the block settle
    task automatic drain();
        while (chars_taken != chars_queued || expected_parses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed numbers with random framing; some pure noise
    task automatic push_random_string();
        int lim;
        int ndig;
        int pick;
        lim = ((cfg_vbytes > hsp_pkg::MAX_BYTES_DEF) ? hsp_pkg::MAX_BYTES_DEF
                                                     : int'(cfg_vbytes)) * 2;
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(1, 255)));
            push_char(hsp_pkg::CH_NUL);
            return;
        end
        repeat ($urandom_range(0, 2)) push_char(hsp_pkg::CH_SPACE);
        pick = int'($urandom_range(3));
        if (pick == 0)
            push_text("0x", 1'b0);
        else if (pick == 1)
            push_text("0X", 1'b0);
        repeat ($urandom_range(0, 2)) push_char(hsp_pkg::CH_ZERO);
        pick = int'($urandom_range(9));
        if (pick == 0)
            ndig = 0;
        else if (pick == 1)
            ndig = lim + 1;
        else if (pick == 2)
            ndig = lim;
        else
            ndig = int'($urandom_range(1, (lim > 0) ? lim : 1));
        repeat (ndig) push_char(hex_pool[$urandom_range(hex_pool.len() - 1)]);
        pick = int'($urandom_range(9));
        case (pick)
            4:
            begin
                repeat ($urandom_range(1, 3)) push_char(hsp_pkg::CH_SPACE);
            end
            5:
            begin
                push_char(hsp_pkg::CH_SPACE);
                repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(1, 255)));
            end
            6:
            begin
                push_char(punct_pool[$urandom_range(punct_pool.len() - 1)]);
                repeat ($urandom_range(0, 3)) push_char(8'($urandom_range(1, 255)));
            end
            7:
                push_char($urandom_range(1) ? hsp_pkg::CH_CR : hsp_pkg::CH_LF);
            8:
                push_char(8'($urandom_range(1, 255)));
            default:
                ;
        endcase
        push_char(hsp_pkg::CH_NUL);
    endtask

    task automatic random_phase(input int budget, input int gap_pct, input int stall_pct);
        int start;
        send_gap_pct   = gap_pct;
        take_stall_pct = stall_pct;
        start          = chars_queued;
        while (chars_queued - start < budget)
            push_random_string();
        drain();
    endtask

    // ---------------------------------------------------------------- test sequence

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        char_bus.valid     = 1'b0;
        char_bus.character = '0;
        result_bus.ready   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: prefixes, empties, widest value, terminators
        push_text("0x1A2b");
        push_text("  0XfF  ");
        push_text("0");
        push_text("000");
        push_text("");
        push_text("0x");
        push_text("00x5");
        push_text("ffffffffffffffff");
        push_text("1ffffffffffffffff");
        push_text("12,zz");
        push_text("12g");
        push_text("!");
        push_text("a\tb");
        push_text("12", 1'b0);
        push_char(hsp_pkg::CH_CR);
        push_char(hsp_pkg::CH_NUL);
        push_text("7", 1'b0);
        push_char(hsp_pkg::CH_LF);
        push_char(hsp_pkg::CH_NUL);
        push_text("3", 1'b0);
        push_char(8'hFF);
        push_char(hsp_pkg::CH_NUL);
        push_text("5");
        // leave a number open across the mode change
        push_text("9", 1'b0);
        drain();

        // Strict mode: only spaces may trail the number
        write_reg(hsp_pkg::REG_STRICT, 32'd1);
        push_text(" x");
        push_text("12 ");
        push_text("  7  ");
        push_text("12,");
        push_text("0x0 ");
        drain();

        // Narrowest and out-of-range value widths
        write_reg(hsp_pkg::REG_STRICT, 32'd0);
        write_reg(hsp_pkg::REG_VBYTES, 32'd1);
        push_text("ff");
        push_text("100");
        push_text("0001");
        drain();
        write_reg(hsp_pkg::REG_VBYTES, 32'd0);
        push_text("0");
        push_text("1");
        push_text("0x00");
        drain();
        write_reg(hsp_pkg::REG_VBYTES, 32'd15);
        push_text("123456789abcdef0");
        push_text("123456789abcdef01");
        drain();

        // Random strings under several settings and idling mixes
        write_reg(hsp_pkg::REG_VBYTES, 32'd8);
        random_phase(50, 0, 0);
        write_reg(hsp_pkg::REG_STRICT, 32'd1);
        random_phase(50, 73, 0);
        write_reg(hsp_pkg::REG_STRICT, 32'd0);
        write_reg(hsp_pkg::REG_VBYTES, 32'd1);
        random_phase(50, 0, 73);
        write_reg(hsp_pkg::REG_STRICT, 32'd1);
        write_reg(hsp_pkg::REG_VBYTES, 32'd4);
        random_phase(50, 10, 10);
        write_reg(hsp_pkg::REG_STRICT, 32'd0);
        write_reg(hsp_pkg::REG_VBYTES, 32'd0);
        random_phase(30, 10, 10);

        // Back up the input behind a long result stall
        write_reg(hsp_pkg::REG_VBYTES, 32'd15);
        send_gap_pct   = 0;
        take_stall_pct = 0;
        while (chars_queued < chars_taken + 40)
            push_random_string();
        squeeze_start = 1'b1;
        drain();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_parses.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/hsp_pkg.sv
rtl/core/hsp_char_if.sv
rtl/core/hsp_result_if.sv
rtl/core/hex_string_parser.sv
rtl/core/hsp_checker.sv
tb/testbench.sv
